FILE: design/tvdc_pkg.sv
// Shared types, constants and helpers for the text value delimiter chooser.
package tvdc_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int QDEPTH = 4;

  localparam logic [2:0] KIND_BARE      = 3'd0;
  localparam logic [2:0] KIND_APOS      = 3'd1;
  localparam logic [2:0] KIND_QUOTE     = 3'd2;
  localparam logic [2:0] KIND_TRIPLE_AP = 3'd3;
  localparam logic [2:0] KIND_TRIPLE_QU = 3'd4;
  localparam logic [2:0] KIND_BLOCK     = 3'd5;

  localparam logic [1:0] REG_ALLOW_BARE   = 2'd0;
  localparam logic [1:0] REG_ALLOW_TRIPLE = 2'd1;
  localparam logic [1:0] REG_LINE_LIMIT   = 2'd2;

  localparam logic [15:0] U_TAB = 16'h09, U_LF = 16'h0A, U_VT = 16'h0B,
    U_CR = 16'h0D, U_SP = 16'h20, U_DQ = 16'h22, U_HASH = 16'h23,
    U_DOLLAR = 16'h24, U_SQ = 16'h27, U_SEMI = 16'h3B, U_BSL = 16'h5C,
    U_UNDER = 16'h5F;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  delimiter_kind;
    logic [23:0] line_count;
    logic [23:0] total_units;
    logic [23:0] first_line_units;
    logic [23:0] last_line_units;
    logic [23:0] longest_line_units;
    logic        has_newline_semicolon;
    logic [23:0] longest_semicolon_run;
    logic        trailing_blank;
    logic        backslash_start;
  } out_req_t;

  // Classified unit passed from front to back.
  typedef struct packed {
    logic [15:0] unit;
    logic        is_end;
    logic        has_unit;
    logic        nxt_lf;
    logic        nxt_semi;
  } judged_t;

  function automatic logic ci(input logic [15:0] u, input logic [7:0] lower);
    return (u | 16'h20) == {8'h00, lower};
  endfunction

endpackage

FILE: design/tvdc_front.sv
// Front end: holds one unit back so its successor is known, then queues it.
module tvdc_front import tvdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  in_req_t in_req,
  input  logic    in_valid,
  output logic    in_ready,
  output judged_t q_data,
  output logic    q_push,
  input  logic    q_full
);
  logic [15:0] held_unit;
  logic        held_valid;

  // Push happens when a held unit is judged or when an end marker arrives.
  logic need_push;
  assign need_push = held_valid || in_req.end_of_string;
  assign in_ready  = !(need_push && q_full);
  assign q_push    = in_valid && in_ready && need_push;

  always_comb begin
    q_data.unit     = held_unit;
    q_data.is_end   = 1'b0;
    q_data.has_unit = held_valid;
    q_data.nxt_lf   = !in_req.end_of_string && in_req.code_unit == U_LF;
    q_data.nxt_semi = !in_req.end_of_string && in_req.code_unit == U_SEMI;
    if (in_req.end_of_string) begin
      q_data.is_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_unit  <= '0;
    end else if (in_valid && in_ready) begin
      held_valid <= !in_req.end_of_string;
      held_unit  <= in_req.code_unit;
    end
  end
endmodule

FILE: design/tvdc_queue.sv
// Short queue between the front and back ends.
module tvdc_queue import tvdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  judged_t wr_data,
  input  logic    push,
  output logic    full,
  output judged_t rd_data,
  output logic    not_empty,
  input  logic    pop
);
  localparam int AW = $clog2(QDEPTH);
  judged_t mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full      = cnt == (AW+1)'(QDEPTH);
  assign not_empty = cnt != '0;
  assign rd_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

FILE: design/tvdc_back.sv
// Back end: statistics update per unit, delimiter choice on end marker.
module tvdc_back import tvdc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     allow_bare,
  input  logic     allow_triple,
  input  logic [15:0] line_length_limit,
  input  judged_t  q_data,
  input  logic     q_valid,
  output logic     q_pop,
  output out_req_t out_req,
  output logic     out_valid,
  input  logic     out_ready
);
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CMAX = '1;

  logic [CW-1:0] unit_total, newline_total, return_total, pair_total;
  logic [CW-1:0] first_len, current_len, longest_len, semi_run, semi_run_best;
  logic [2:0]  class_flags;
  logic [1:0]  ar, qr, triple_seen, line_flags;
  logic [15:0] unit_before_held, first_line_last_nonblank;
  logic [15:0] lead [8];

  // An end marker that closes a nonempty value first judges its held unit,
  // then chooses once that is done and the output is free.
  logic out_free, end_stage, judge_end, take, fin;
  assign out_free  = !out_valid || out_ready;
  assign judge_end = q_valid && q_data.is_end && q_data.has_unit && !end_stage;
  assign fin       = q_valid && q_data.is_end && (!q_data.has_unit || end_stage) &&
                     out_free;
  assign take      = (q_valid && !q_data.is_end) || judge_end;
  assign q_pop     = (q_valid && !q_data.is_end) || fin;

  function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
    return (v != CMAX) ? v + 1'b1 : v;
  endfunction
  function automatic logic [23:0] cap(input logic [CW-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'hFFFFFF) ? 24'hFFFFFF : w[23:0];
  endfunction
  function automatic logic [23:0] cap_wide(input logic [CW+1:0] v);
    logic [33:0] w;
    w = 34'(v);
    return (w > 34'hFFFFFF) ? 24'hFFFFFF : w[23:0];
  endfunction

  // Per-unit next values.
  logic [15:0] u;
  logic in_first, brk, is_sp, is_semi;
  logic [CW-1:0] ut_n, nl_n, rt_n, pr_n, fl_n, cl_n, ll_n, sr_n, sb_n;
  logic [1:0] ar_n, qr_n, ts_n, lf_n;
  logic [2:0] cf_n;
  logic [15:0] fnb_n;

  always_comb begin
    u = q_data.unit;
    in_first = newline_total == '0 && return_total == '0;
    is_sp = u == U_SP || u == U_TAB || u == 16'h5B || u == 16'h5D ||
            u == 16'h7B || u == 16'h7D;
    is_semi = u == U_SEMI;
    cf_n = class_flags | {u == U_DQ, u == U_SQ, is_sp};
    ar_n = (u == U_SQ) ? ((ar != 2'd3) ? ar + 1'b1 : ar) : 2'd0;
    qr_n = (u == U_DQ) ? ((qr != 2'd3) ? qr + 1'b1 : qr) : 2'd0;
    ts_n = triple_seen | {qr_n == 2'd3, ar_n == 2'd3};
    nl_n = (u == U_LF) ? inc(newline_total) : newline_total;
    rt_n = (u == U_CR) ? inc(return_total) : return_total;
    pr_n = pair_total; sr_n = semi_run; sb_n = semi_run_best;
    cl_n = current_len; brk = 1'b0;
    if (u == U_CR) begin
      if (q_data.nxt_lf) pr_n = inc(pair_total);
      else brk = 1'b1;
    end else if (u == U_LF) begin
      brk = 1'b1;
    end else if (is_semi) begin
      sr_n = inc(semi_run);
      if (sr_n > semi_run_best) sb_n = sr_n;
      cl_n = inc(current_len);
    end else begin
      sr_n = '0;
      cl_n = inc(current_len);
    end
    lf_n = line_flags; fl_n = first_len; ll_n = longest_len;
    if (brk) begin
      if (q_data.nxt_semi) lf_n[0] = 1'b1;
      if (unit_total != '0 && (unit_before_held == U_SP ||
          unit_before_held == U_TAB || unit_before_held == U_VT)) lf_n[1] = 1'b1;
      if ((CW+1)'(nl_n) + (CW+1)'(rt_n) == (CW+1)'(1)) fl_n = cl_n;
      if (cl_n > longest_len) ll_n = cl_n;
      sr_n = '0; cl_n = '0;
    end
    fnb_n = first_line_last_nonblank;
    if (in_first && u != U_CR && u != U_LF && u != U_SP && u != U_TAB) fnb_n = u;
    ut_n = inc(unit_total);
  end

  // End-of-value evaluation on current state.
  logic [CW+1:0] breaks, lines;
  logic single, resv, bare_ok;
  logic [CW-1:0] fl_e, ll_e;
  logic signed [CW+2:0] lim, lng, cur, fst;
  logic [2:0] trip, kind;
  logic [15:0] c0;

  always_comb begin
    c0 = lead[0];
    breaks = (CW+2)'(newline_total) + (CW+2)'(return_total) - (CW+2)'(pair_total);
    lines = breaks + 1'b1;
    single = breaks == '0;
    fl_e = single ? current_len : first_len;
    ll_e = (current_len > longest_len) ? current_len : longest_len;
    lim = (CW+3)'(line_length_limit);
    lng = (CW+3)'(ll_e);
    cur = (CW+3)'(current_len);
    fst = (CW+3)'(fl_e);
    resv = 1'b0;
    if (ci(c0, "d"))
      resv = ci(lead[1], "a") && ci(lead[2], "t") && ci(lead[3], "a") && lead[4] == U_UNDER;
    else if (ci(c0, "g"))
      resv = ci(lead[1], "l") && ci(lead[2], "o") && ci(lead[3], "b") &&
             ci(lead[4], "a") && ci(lead[5], "l") && lead[6] == U_UNDER &&
             unit_total == CW'(7);
    else if (ci(c0, "l"))
      resv = ci(lead[1], "o") && ci(lead[2], "o") && ci(lead[3], "p") &&
             lead[4] == U_UNDER && unit_total == CW'(5);
    else if (ci(c0, "s")) begin
      if (ci(lead[1], "a"))
        resv = ci(lead[2], "v") && ci(lead[3], "e") && lead[4] == U_UNDER;
      else if (ci(lead[1], "t"))
        resv = ci(lead[2], "o") && ci(lead[3], "p") && lead[4] == U_UNDER &&
               unit_total == CW'(5);
    end
    trip = !triple_seen[0] ? KIND_TRIPLE_AP : !triple_seen[1] ? KIND_TRIPLE_QU : KIND_BLOCK;
    bare_ok = allow_bare && !class_flags[0] && c0 != U_SQ && c0 != U_DQ &&
              c0 != U_HASH && c0 != U_DOLLAR && c0 != U_UNDER && c0 != U_SEMI && !resv;
    kind = KIND_BLOCK;
    if (lng > lim) kind = KIND_BLOCK;
    else if (single) begin
      if (bare_ok) kind = KIND_BARE;
      else if (lng <= lim - 2 && !class_flags[1]) kind = KIND_APOS;
      else if (lng <= lim - 2 && !class_flags[2]) kind = KIND_QUOTE;
      else if (allow_triple && lng <= lim - 6) kind = trip;
    end else if (allow_triple && cur < lim - 3 && fst < lim - 3) kind = trip;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_req.delimiter_kind        <= kind;
      out_req.line_count            <= cap_wide(lines);
      out_req.total_units           <= cap(unit_total);
      out_req.first_line_units      <= cap(fl_e);
      out_req.last_line_units       <= cap(current_len);
      out_req.longest_line_units    <= cap(ll_e);
      out_req.has_newline_semicolon <= line_flags[0];
      out_req.longest_semicolon_run <= cap(semi_run_best);
      out_req.trailing_blank        <= line_flags[1];
      out_req.backslash_start       <= kind == KIND_BLOCK && c0 != U_SEMI &&
                                       fl_e != '0 && first_line_last_nonblank == U_BSL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fin) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || fin) end_stage <= 1'b0;
    else if (judge_end) end_stage <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      unit_total <= '0; newline_total <= '0; return_total <= '0; pair_total <= '0;
      first_len <= '0; current_len <= '0; longest_len <= '0;
      semi_run <= '0; semi_run_best <= '0; class_flags <= '0;
      ar <= '0; qr <= '0; triple_seen <= '0; line_flags <= '0;
      unit_before_held <= '0; first_line_last_nonblank <= '0;
      for (int i = 0; i < 8; i++) lead[i] <= '0;
    end else if (take) begin
      unit_total <= ut_n; newline_total <= nl_n; return_total <= rt_n;
      pair_total <= pr_n; first_len <= fl_n; current_len <= cl_n;
      longest_len <= ll_n; semi_run <= sr_n; semi_run_best <= sb_n;
      class_flags <= cf_n; ar <= ar_n; qr <= qr_n; triple_seen <= ts_n;
      line_flags <= lf_n; unit_before_held <= u; first_line_last_nonblank <= fnb_n;
      for (int i = 0; i < 8; i++)
        if (unit_total == CW'(i)) lead[i] <= u;
    end
  end
endmodule

FILE: design/text_value_delimiter_chooser_top.sv
// Top level of the text value delimiter chooser.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_ready   | in_req  (code_unit, end_of_string)
//  out     | out_valid / out_ready | out_req (delimiter kind, statistics)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle is sustained while the queue has room: each unit
// is held in the front end for one request so its successor is known, then
// pushed into the four-entry queue and judged by the back end in the cycle
// it is popped. An end marker that closes a nonempty value has the back end
// first judge the held unit and then choose, so a value of n units moves n
// queue entries over n+1 requests. The result is valid the cycle after the
// end marker is popped. Reset (rst, synchronous) clears all stream state and
// restores the register defaults. Out stalls back up through the queue into
// in_ready.
module text_value_delimiter_chooser_top import tvdc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  in_req_t     in_req,
  input  logic        in_valid,
  output logic        in_ready,
  output out_req_t    out_req,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  logic allow_bare, allow_triple;
  logic [15:0] line_length_limit;

  // Registers take writes at any time.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_bare <= 1'b1;
      allow_triple <= 1'b1;
      line_length_limit <= 16'd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALLOW_BARE:   allow_bare <= cfg_data[0];
        REG_ALLOW_TRIPLE: allow_triple <= cfg_data[0];
        REG_LINE_LIMIT:   line_length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  judged_t f_data, b_data;
  logic f_push, q_full, q_ne, q_pop;

  tvdc_front u_front (
    .clk, .rst, .in_req, .in_valid, .in_ready,
    .q_data(f_data), .q_push(f_push), .q_full
  );

  tvdc_queue u_queue (
    .clk, .rst, .wr_data(f_data), .push(f_push), .full(q_full),
    .rd_data(b_data), .not_empty(q_ne), .pop(q_pop)
  );

  tvdc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst, .allow_bare, .allow_triple, .line_length_limit,
    .q_data(b_data), .q_valid(q_ne), .q_pop,
    .out_req, .out_valid, .out_ready
  );
endmodule
